// ----- rtl/lrl_pkg.sv -----
// Package for the LRU recency list: key type, field widths, reset values
// and the controller state type. No dependencies.
package lrl_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned OCC_W = 4;
  localparam int unsigned CFG_W = 4;

  localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 4'd8;

  typedef logic signed [KEY_W-1:0] key_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TRIM,
    S_EVICT,
    S_SHIFT,
    S_FRONT
  } state_e;

endpackage

// ----- rtl/lrl_access_if.sv -----
// Valid/ready interfaces for the access channel and the result channel.
// Depends on lrl_pkg for the key type and field widths.
interface lrl_access_if;
  import lrl_pkg::*;

  logic valid;
  logic ready;
  key_t access_key;

  modport source (output valid, output access_key, input ready);
  modport sink (input valid, input access_key, output ready);
endinterface

interface lrl_result_if;
  import lrl_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted;
  key_t             evicted_key;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output hit, output evicted, output evicted_key,
                  output occupancy, input ready);
  modport sink (input valid, input hit, input evicted, input evicted_key,
                input occupancy, output ready);
endinterface

// ----- rtl/lru_recency_list.sv -----
// Top level of the LRU recency list: controller, configuration register and
// result register. Depends on lrl_pkg, the channel interfaces and lrl_keystore.

// Keeps up to capacity_limit keys ordered from most to least recently used in
// a single-port-write, registered-read key memory. Each access transaction is
// processed one at a time: the controller scans the memory from the front, one
// key per cycle, then shifts the more recent keys back one slot per cycle and
// writes the accessed key to the front. The controller returns to idle before
// it accepts the next transaction, and a stalled result register holds the
// controller until it drains. A miss with a full store evicts the least recent
// key and reports it. The store starts empty after reset, with capacity_limit
// at 8; a limit of 0 acts as 1 and a limit above CAPACITY acts as CAPACITY.
module lru_recency_list #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lrl_pkg::CFG_W-1:0]   cfg_wdata_i,
  lrl_access_if.sink                  req_i,
  lrl_result_if.source                rsp_o
);
  import lrl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  key_t             key_q;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    widx_q, widx_d;
  logic             hit_q, hit_d;
  logic             ev_q, ev_d;
  key_t             evkey_q, evkey_d;

  logic             out_valid_q;
  logic             out_hit_q;
  logic             out_ev_q;
  key_t             out_evkey_q;
  logic [OCC_W-1:0] out_occ_q;
  logic             out_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  key_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  key_t          mem_rdata;

  logic [LW-1:0] lim_wide;
  logic [CW-1:0] eff_lim;
  logic [CW-1:0] trim_n;
  logic          slot_free;

  // Key memory.
  lrl_keystore #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_keystore (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Effective limit: zero acts as one, values above the slot count saturate.
  always_comb begin
    lim_wide = LW'(cfg_q);
    if (lim_wide == '0) begin
      lim_wide = LW'(1);
    end else if (lim_wide > LW'(CAPACITY)) begin
      lim_wide = LW'(CAPACITY);
    end
    eff_lim = CW'(lim_wide);
    trim_n  = (count_q > eff_lim) ? eff_lim : count_q;
  end

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_LIMIT_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Controller state and occupancy registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Per-transaction working registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    widx_q  <= widx_d;
    hit_q   <= hit_d;
    ev_q    <= ev_d;
    evkey_q <= evkey_d;
    if (req_i.valid && req_i.ready) begin
      key_q <= req_i.access_key;
    end
  end

  // Next state, memory accesses and working register updates.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    widx_d    = widx_q;
    hit_d     = hit_q;
    ev_d      = ev_q;
    evkey_d   = evkey_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = key_q;
    mem_raddr = '0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          hit_d   = 1'b0;
          ev_d    = 1'b0;
          evkey_d = '0;
          idx_d   = '0;
          if (count_q == '0) begin
            state_d = S_TRIM;
          end else begin
            mem_raddr = '0;
            state_d   = S_SCAN;
          end
        end
      end

      // Compare the key read at idx_q; fetch the next one on a mismatch.
      S_SCAN: begin
        if (mem_rdata == key_q) begin
          hit_d = 1'b1;
          if (idx_q == '0) begin
            state_d = S_FRONT;
          end else begin
            mem_raddr = idx_q - AW'(1);
            widx_d    = idx_q;
            state_d   = S_SHIFT;
          end
        end else if ((CW'(idx_q) + CW'(1)) < count_q) begin
          mem_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end else begin
          state_d = S_TRIM;
        end
      end

      // Miss: drop keys beyond the limit, then evict the tail if full.
      S_TRIM: begin
        if (trim_n == eff_lim) begin
          mem_raddr = AW'(trim_n - CW'(1));
          count_d   = trim_n - CW'(1);
          state_d   = S_EVICT;
        end else begin
          count_d = trim_n;
          if (trim_n == '0) begin
            state_d = S_FRONT;
          end else begin
            mem_raddr = AW'(trim_n - CW'(1));
            widx_d    = AW'(trim_n);
            state_d   = S_SHIFT;
          end
        end
      end

      // Capture the evicted key and start moving the rest back.
      S_EVICT: begin
        ev_d    = 1'b1;
        evkey_d = mem_rdata;
        if (count_q == '0) begin
          state_d = S_FRONT;
        end else begin
          mem_raddr = AW'(count_q - CW'(1));
          widx_d    = AW'(count_q);
          state_d   = S_SHIFT;
        end
      end

      // Write the key read from widx_q-1 into widx_q, fetch the one below it.
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = widx_q;
        mem_wdata = mem_rdata;
        if (widx_q == AW'(1)) begin
          state_d = S_FRONT;
        end else begin
          mem_raddr = widx_q - AW'(2);
          widx_d    = widx_q - AW'(1);
        end
      end

      // Place the key at the front and hand over the result.
      S_FRONT: begin
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = key_q;
          out_load  = 1'b1;
          if (!hit_q) begin
            count_d = count_q + CW'(1);
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q   <= hit_q;
      out_ev_q    <= ev_q;
      out_evkey_q <= evkey_q;
      out_occ_q   <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_key = out_evkey_q;
  assign rsp_o.occupancy   = out_occ_q;

endmodule

// ----- rtl/lrl_keystore.sv -----
// Key storage of the LRU recency list: one write port and one read port
// with registered read data. Depends on lrl_pkg for the key type.
module lrl_keystore #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  lrl_pkg::key_t wdata_i,
  input  logic [AW-1:0] raddr_i,
  output lrl_pkg::key_t rdata_o
);
  import lrl_pkg::*;

  key_t mem_q [DEPTH];
  key_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for lru_recency_list: directed and random access traces checked
// against a recency-order predictor. Depends on lrl_pkg and the channel interfaces.
module tb_top;
  import lrl_pkg::*;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned POOL_SIZE   = 12;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    key_t             evicted_key;
    logic [OCC_W-1:0] occupancy;
  } access_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lrl_access_if acc_if ();
  lrl_result_if res_if ();

  lru_recency_list #(.CAPACITY(SLOTS)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (acc_if),
    .rsp_o       (res_if)
  );

  // Predictor state: keys from most to least recent, count and limit register.
  key_t           held_keys [SLOTS];
  int unsigned    held_count = 0;
  logic [CFG_W-1:0] limit_reg = CFG_LIMIT_RESET;

  access_result_t pending_results [$];
  key_t           key_pool [POOL_SIZE];

  bit          idle_on = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned accesses = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned evictions_seen = 0;
  int unsigned limit_writes = 0;
  int unsigned stall_left = 0;

  // Works out the result of one access and updates the recency order.
  function automatic access_result_t predict_access(key_t k);
    access_result_t r;
    int unsigned lim;
    int unsigned pos;
    bit found;
    lim = (limit_reg == 0) ? 1 : ((limit_reg > SLOTS) ? SLOTS : limit_reg);
    r = '0;
    found = 1'b0;
    pos = 0;
    for (int i = 0; i < held_count; i++) begin
      if (!found && held_keys[i] === k) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      for (int i = pos; i > 0; i--) held_keys[i] = held_keys[i-1];
      held_keys[0] = k;
    end else begin
      // Entries beyond a lowered limit go silently before the reported eviction.
      if (held_count > lim) held_count = lim;
      if (held_count >= lim) begin
        r.evicted = 1'b1;
        r.evicted_key = held_keys[held_count-1];
        held_count--;
      end
      for (int i = held_count; i > 0; i--) held_keys[i] = held_keys[i-1];
      held_keys[0] = k;
      held_count++;
    end
    r.occupancy = 4'(held_count);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results pending", cycles,
                 pending_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side: check each transaction, then pick the next ready value.
  initial begin
    access_result_t want;
    access_result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (res_if.valid && res_if.ready) begin
          got = '{res_if.hit, res_if.evicted, res_if.evicted_key, res_if.occupancy};
          results_seen++;
          if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Unexpected result: hit=%b evicted=%b key=%h occ=%0d",
                       got.hit, got.evicted, got.evicted_key, got.occupancy);
          end else begin
            want = pending_results.pop_front();
            if (want.hit) hits_seen++;
            if (want.evicted) evictions_seen++;
            if (got !== want) begin
              mismatches++;
              if (mismatches <= 10)
                $display("Mismatch on result %0d: expected hit=%b evicted=%b key=%h occ=%0d, got hit=%b evicted=%b key=%h occ=%0d",
                         results_seen, want.hit, want.evicted, want.evicted_key,
                         want.occupancy, got.hit, got.evicted, got.evicted_key,
                         got.occupancy);
            end
          end
        end
        if (stall_left > 0) begin
          stall_left--;
          res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 13) - 1;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // Sends one access transaction and records its expected result.
  task automatic send_access(key_t k);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      acc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    acc_if.valid <= 1'b1;
    acc_if.access_key <= k;
    do @(posedge clk_i); while (!acc_if.ready);
    pending_results.push_back(predict_access(k));
    accesses++;
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic drain_results();
    acc_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the capacity limit; only called with the block idle.
  task automatic write_limit(logic [CFG_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    limit_reg = value;
    limit_writes++;
    cfg_we <= 1'b0;
  endtask

  // Extreme keys, two hits at the same position, one-bit neighbors and a full store.
  task automatic test_basic_order();
    send_access(32'sh0000_0000);
    send_access(32'shFFFF_FFFF);
    send_access(32'sh8000_0000);
    send_access(32'sh7FFF_FFFF);
    send_access(32'sh0000_0000);
    send_access(32'shFFFF_FFFF);
    send_access(32'sh7FFF_FFFE);
    send_access(32'sh0000_0001);
    send_access(32'sh5555_5555);
    send_access(32'shAAAA_AAAA);
    send_access(32'sh1234_5678);
  endtask

  // The store is full, then the limit drops below the occupancy.
  task automatic test_limit_lowered();
    write_limit(4'd3);
    send_access(32'sh8000_0000);
    send_access(32'shAAAA_AAAA);
    send_access(32'sh0BAD_F00D);
  endtask

  // A limit of zero holds a single key.
  task automatic test_limit_zero();
    write_limit(4'd0);
    send_access(32'sh0BAD_F00D);
    send_access(32'sh0BAD_F00C);
    send_access(32'sh0BAD_F00C);
  endtask

  // Random traces under one limit: mostly held and pooled keys, some noise.
  task automatic test_random_phase(logic [CFG_W-1:0] lim, int unsigned count, bit idling);
    key_t k;
    int unsigned pick;
    write_limit(lim);
    idle_on = idling;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (i > 0 && $urandom_range(0, 2) == 0)
        key_pool[i] = key_pool[i-1] ^ (32'sh1 << $urandom_range(0, 31));
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 && held_count > 0)
        k = held_keys[$urandom_range(0, held_count - 1)];
      else if (pick < 75)
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 90)
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'sh1 << $urandom_range(0, 31));
      else
        k = $urandom;
      send_access(k);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] limits [14] = '{4'd8, 4'd15, 4'd1, 4'd4, 4'd0, 4'd9, 4'd6,
                                      4'd2, 4'd12, 4'd3, 4'd7, 4'd5, 4'd8, 4'd1};
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    acc_if.valid <= 1'b0;
    acc_if.access_key <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_order();
    test_limit_lowered();
    test_limit_zero();
    // The last two phases run without idling on either side.
    for (int p = 0; p < 14; p++)
      test_random_phase(limits[p], 85, (p < 12) && (p % 3 != 2));

    drain_results();
    repeat (30) @(posedge clk_i);
    $display("Ran %0d accesses under %0d limit writes: %0d hits, %0d evictions.",
             accesses, limit_writes, hits_seen, evictions_seen);
    $display("Results checked: %0d, mismatches: %0d", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lrl_pkg.sv
rtl/lrl_access_if.sv
rtl/lrl_keystore.sv
rtl/lru_recency_list.sv
dv/tb_top.sv
